### rtl/cubic_bezier_flattener_defines.svh
// Assertion macros used by the cubic Bezier flattener top level.
`ifndef CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_DEFINES_SVH

// Check on every clock edge outside reset.
`define CBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cbf_pkg.sv
// Types, constants and fixed-point helpers of the cubic Bezier flattener.
`default_nettype none

package cbf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int K_W        = $clog2(MAX_POINTS);
  localparam int T_W        = 17;

  localparam logic [T_W-1:0] STEP_MIN   = 17'd1040;
  localparam logic [T_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [T_W-1:0] STEP_RESET = 17'd1311;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    coord_t          p0_x;
    coord_t          p0_y;
    coord_t          p1_x;
    coord_t          p1_y;
    coord_t          p2_x;
    coord_t          p2_y;
    coord_t          p3_x;
    coord_t          p3_y;
    logic [T_W-1:0]  step;
  } job_t;

  function automatic q16_t to_q16(coord_t c);
    return {c, 16'h0000};
  endfunction

  // a + round((b - a) * t / 2^16), ties towards plus infinity
  function automatic q16_t lerp(q16_t a, q16_t b, logic [T_W-1:0] t);
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] rnd;
    diff = $signed({b[31], b}) - $signed({a[31], a});
    prod = diff * $signed({1'b0, t});
    rnd  = prod + 51'sd32768;
    return a + q16_t'(rnd >>> 16);
  endfunction

  // Truncate towards zero to an integer.
  function automatic coord_t to_int(q16_t v);
    q16_t adj;
    adj = v + (v[31] ? 32'sd65535 : 32'sd0);
    return adj[31:16];
  endfunction

endpackage

`default_nettype wire

### rtl/cbf_front.sv
// Front end: takes segments, clamps the step and holds one job for the queue.
`default_nettype none

module cbf_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     seg_valid,
  output logic                          seg_ready,
  input  wire cbf_pkg::coord_t          p0_x,
  input  wire cbf_pkg::coord_t          p0_y,
  input  wire cbf_pkg::coord_t          p1_x,
  input  wire cbf_pkg::coord_t          p1_y,
  input  wire cbf_pkg::coord_t          p2_x,
  input  wire cbf_pkg::coord_t          p2_y,
  input  wire cbf_pkg::coord_t          p3_x,
  input  wire cbf_pkg::coord_t          p3_y,
  input  wire logic [cbf_pkg::T_W-1:0]  t_step,
  output cbf_pkg::job_t                 job,
  output logic                          job_valid,
  input  wire logic                     job_ready
);

  logic [cbf_pkg::T_W-1:0] step_eff;

  assign step_eff  = (t_step < cbf_pkg::STEP_MIN) ? cbf_pkg::STEP_MIN : t_step;
  assign seg_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (seg_ready) begin
      job_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      job.p0_x <= p0_x;
      job.p0_y <= p0_y;
      job.p1_x <= p1_x;
      job.p1_y <= p1_y;
      job.p2_x <= p2_x;
      job.p2_y <= p2_y;
      job.p3_x <= p3_x;
      job.p3_y <= p3_y;
      job.step <= step_eff;
    end
  end

endmodule

`default_nettype wire

### rtl/cbf_queue.sv
// Two-entry job queue between the front end and the point generator.
`default_nettype none

module cbf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cbf_pkg::job_t  wr_job,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output cbf_pkg::job_t       rd_job,
  output logic                rd_valid,
  input  wire logic           rd_ready
);

  cbf_pkg::job_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

### rtl/cbf_back.sv
// Point generator: steps t over a job and runs three pipelined lerp levels.
`default_nettype none

module cbf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cbf_pkg::job_t  job,
  input  wire logic           job_valid,
  output logic                job_ready,
  output logic                point_valid,
  input  wire logic           point_ready,
  output cbf_pkg::coord_t     point_x,
  output cbf_pkg::coord_t     point_y,
  output logic                is_move,
  output logic                last
);

  logic [cbf_pkg::T_W-1:0] t;
  logic [cbf_pkg::K_W-1:0] k;
  logic [cbf_pkg::T_W:0]   t_sum;
  logic                    run_end;
  logic                    adv;
  logic                    issue;

  // first level
  logic                    s1_valid;
  cbf_pkg::q16_t           s1_ax, s1_bx, s1_dx, s1_ay, s1_by, s1_dy;
  logic [cbf_pkg::T_W-1:0] s1_t;
  logic                    s1_move, s1_last;

  // second level
  logic                    s2_valid;
  cbf_pkg::q16_t           s2_ex, s2_fx, s2_ey, s2_fy;
  logic [cbf_pkg::T_W-1:0] s2_t;
  logic                    s2_move, s2_last;

  // the whole pipe holds while a finished point waits
  assign adv     = !point_valid || point_ready;
  assign t_sum   = {1'b0, t} + {1'b0, job.step};
  assign run_end = (t_sum > {1'b0, cbf_pkg::ONE_Q16}) ||
                   (k == cbf_pkg::K_W'(cbf_pkg::MAX_POINTS - 1));
  assign issue     = adv && job_valid;
  assign job_ready = issue && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
      k <= '0;
    end else if (issue) begin
      if (run_end) begin
        t <= '0;
        k <= '0;
      end else begin
        t <= t_sum[cbf_pkg::T_W-1:0];
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      point_valid <= 1'b0;
    end else if (adv) begin
      s1_valid    <= issue;
      s2_valid    <= s1_valid;
      point_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p0_x), cbf_pkg::to_q16(job.p1_x), t);
      s1_bx   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p1_x), cbf_pkg::to_q16(job.p2_x), t);
      s1_dx   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p2_x), cbf_pkg::to_q16(job.p3_x), t);
      s1_ay   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p0_y), cbf_pkg::to_q16(job.p1_y), t);
      s1_by   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p1_y), cbf_pkg::to_q16(job.p2_y), t);
      s1_dy   <= cbf_pkg::lerp(cbf_pkg::to_q16(job.p2_y), cbf_pkg::to_q16(job.p3_y), t);
      s1_t    <= t;
      s1_move <= (k == '0);
      s1_last <= run_end;

      s2_ex   <= cbf_pkg::lerp(s1_ax, s1_bx, s1_t);
      s2_fx   <= cbf_pkg::lerp(s1_bx, s1_dx, s1_t);
      s2_ey   <= cbf_pkg::lerp(s1_ay, s1_by, s1_t);
      s2_fy   <= cbf_pkg::lerp(s1_by, s1_dy, s1_t);
      s2_t    <= s1_t;
      s2_move <= s1_move;
      s2_last <= s1_last;

      point_x <= cbf_pkg::to_int(cbf_pkg::lerp(s2_ex, s2_fx, s2_t));
      point_y <= cbf_pkg::to_int(cbf_pkg::lerp(s2_ey, s2_fy, s2_t));
      is_move <= s2_move;
      last    <= s2_last;
    end
  end

endmodule

`default_nettype wire

### rtl/cubic_bezier_flattener.sv
// Cubic Bezier flattener (de Casteljau): top level.
//
// Segment channel seg_valid/seg_ready carries four control points p0..p3.
// Point channel point_valid/point_ready returns the curve points of each
// segment in order, at t = k * step, with is_move on the first point and
// last on the final one. cfg_we/cfg_wdata write t_step (unsigned Q1.16, reset 1311);
// a step under 1040 is used as 1040, a step over 1.0 gives a single point.
// Each segment yields floor(65536 / step) + 1 points, at most 64.
// The first point of a segment passes the front-end job register, the queue
// and the s1, s2 and output registers of the point generator. Throughput: one
// point per cycle while the receiver takes them; the t sequencer in the point
// generator issues one point per cycle unless the pipe holds. The two-entry
// queue holds the running segment and one waiting; the front end one more.
// Reset empties the queue and the pipe and restores the step register.
// When the receiver stalls the point pipe holds, the queue fills and then
// seg_ready drops.
`default_nettype none

`include "cubic_bezier_flattener_defines.svh"

module cubic_bezier_flattener (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [cbf_pkg::T_W-1:0]  cfg_wdata,
  input  wire logic                     seg_valid,
  output logic                          seg_ready,
  input  wire cbf_pkg::coord_t          p0_x,
  input  wire cbf_pkg::coord_t          p0_y,
  input  wire cbf_pkg::coord_t          p1_x,
  input  wire cbf_pkg::coord_t          p1_y,
  input  wire cbf_pkg::coord_t          p2_x,
  input  wire cbf_pkg::coord_t          p2_y,
  input  wire cbf_pkg::coord_t          p3_x,
  input  wire cbf_pkg::coord_t          p3_y,
  output logic                          point_valid,
  input  wire logic                     point_ready,
  output cbf_pkg::coord_t               point_x,
  output cbf_pkg::coord_t               point_y,
  output logic                          is_move,
  output logic                          last
);

  logic [cbf_pkg::T_W-1:0] t_step;
  cbf_pkg::job_t           front_job;
  logic                    front_valid;
  logic                    front_ready;
  cbf_pkg::job_t           q_job;
  logic                    q_valid;
  logic                    q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_step <= cbf_pkg::STEP_RESET;
    end else if (cfg_we) begin
      t_step <= cfg_wdata;
    end
  end

  cbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .p0_x      (p0_x),
    .p0_y      (p0_y),
    .p1_x      (p1_x),
    .p1_y      (p1_y),
    .p2_x      (p2_x),
    .p2_y      (p2_y),
    .p3_x      (p3_x),
    .p3_y      (p3_y),
    .t_step    (t_step),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  cbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  cbf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (q_job),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .is_move     (is_move),
    .last        (last)
  );

  `CBF_ASSERT_ALWAYS(a_reset_empties_pipe, rst |=> !point_valid, "point valid after reset")
  `CBF_ASSERT(a_run_continues, (point_valid && point_ready && !last) |=> !(point_valid && is_move), "pen move inside a run")
  `CBF_ASSERT(a_run_starts_with_move, (point_valid && point_ready && last) |=> !(point_valid && !is_move), "run starts without pen move")

endmodule

`default_nettype wire
